// ===== rtl/core/cosine_sum_waveform_sweep_assert.svh =====
// Assertion macros used by the sweep generator control module.
`ifndef COSINE_SUM_WAVEFORM_SWEEP_ASSERT_SVH
`define COSINE_SUM_WAVEFORM_SWEEP_ASSERT_SVH

// Checks that cons holds in the same cycle as ante.
`define CSSW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that cons holds in the cycle after ante.
`define CSSW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cssw_pkg.sv =====
// Package with types, codes and the cosine table function of the sweep generator.
`default_nettype none
package cssw_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_CARRIER = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TONE_A  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TONE_B  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_DEPTH_A = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DEPTH_B = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_OFFSET  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN    = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_STEP    = 3'd7;

  localparam logic REQ_START = 1'b0;

  localparam logic [1:0] FORM_SINGLE = 2'd0;
  localparam logic [1:0] FORM_DUAL   = 2'd1;
  localparam logic [1:0] FORM_MOD    = 2'd2;
  localparam logic [1:0] FORM_SPARE  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLO, ST_CHI, ST_ALO, ST_AHI, ST_BLO, ST_BHI,
    ST_DA, ST_DB, ST_CG, ST_FIN, ST_RES
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_C_LO, OP_C_HI, OP_A_LO, OP_A_HI, OP_B_LO, OP_B_HI,
    OP_DA, OP_DB, OP_CG, OP_FIN, OP_RES
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } cssw_cmd_t;

  typedef struct packed {
    logic go;
    logic out_free;
  } cssw_sts_t;

  localparam longint Q30_ONE    = longint'(1) << 30;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;
  localparam longint TERM_DIV_0 = 132 * Q30_ONE;
  localparam longint TERM_DIV_1 = 90 * Q30_ONE;
  localparam longint TERM_DIV_2 = 56 * Q30_ONE;
  localparam longint TERM_DIV_3 = 30 * Q30_ONE;
  localparam longint TERM_DIV_4 = 12 * Q30_ONE;
  localparam longint TERM_DIV_5 = 2 * Q30_ONE;

  // Quarter-wave cosine entry in Q1.14 from a Taylor series evaluated in Q30.
  function automatic logic [14:0] qcos_entry(input int k, input int bits);
    longint theta;
    longint x2;
    longint t;
    theta = (TWO_PI_Q30 * longint'(k)) >>> bits;
    x2 = (theta * theta) >>> 30;
    t = Q30_ONE;
    t = Q30_ONE - (x2 * t) / TERM_DIV_0;
    t = Q30_ONE - (x2 * t) / TERM_DIV_1;
    t = Q30_ONE - (x2 * t) / TERM_DIV_2;
    t = Q30_ONE - (x2 * t) / TERM_DIV_3;
    t = Q30_ONE - (x2 * t) / TERM_DIV_4;
    t = Q30_ONE - (x2 * t) / TERM_DIV_5;
    if (t < 0) t = 0;
    if (t > Q30_ONE) t = Q30_ONE;
    return 15'((t + 32768) >>> 16);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/cssw_in_if.sv =====
// Request channel interface of the sweep generator.
`default_nettype none
interface cssw_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [1:0]         form;
  logic signed [31:0] start_x;
  logic signed [31:0] end_x;

  modport source (output valid, output req_type, output form, output start_x,
                  output end_x, input ready);
  modport sink (input valid, input req_type, input form, input start_x,
                input end_x, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cssw_out_if.sv =====
// Result channel interface of the sweep generator.
`default_nettype none
interface cssw_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/cssw_ctrl.sv =====
// Sequencing state machine of the sweep generator.
`default_nettype none
`include "cosine_sum_waveform_sweep_assert.svh"
module cssw_ctrl
  import cssw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire cssw_sts_t sts,
  output cssw_cmd_t      cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready = 1'b0;
    cmd.load = 1'b0;
    cmd.op = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && sts.go) state_nxt = ST_CLO;
      end
      ST_CLO: begin
        cmd.op = OP_C_LO;
        state_nxt = ST_CHI;
      end
      ST_CHI: begin
        cmd.op = OP_C_HI;
        state_nxt = ST_ALO;
      end
      ST_ALO: begin
        cmd.op = OP_A_LO;
        state_nxt = ST_AHI;
      end
      ST_AHI: begin
        cmd.op = OP_A_HI;
        state_nxt = ST_BLO;
      end
      ST_BLO: begin
        cmd.op = OP_B_LO;
        state_nxt = ST_BHI;
      end
      ST_BHI: begin
        cmd.op = OP_B_HI;
        state_nxt = ST_DA;
      end
      ST_DA: begin
        cmd.op = OP_DA;
        state_nxt = ST_DB;
      end
      ST_DB: begin
        cmd.op = OP_DB;
        state_nxt = ST_CG;
      end
      ST_CG: begin
        cmd.op = OP_CG;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        cmd.op = OP_FIN;
        state_nxt = ST_RES;
      end
      ST_RES: begin
        cmd.op = OP_RES;
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `CSSW_ASSERT_NEXT(a_go_starts, state_r == ST_IDLE && in_valid && sts.go, state_r == ST_CLO, "accepted beat with a point did not start the sequence")
  `CSSW_ASSERT_NEXT(a_nogo_idle, state_r == ST_IDLE && !sts.go, state_r == ST_IDLE, "beat without a point left idle")
  `CSSW_ASSERT_NEXT(a_res_hold, state_r == ST_RES && !sts.out_free, state_r == ST_RES, "result left before the output stage was free")

endmodule
`default_nettype wire

// ===== rtl/core/cssw_dp.sv =====
// Datapath of the sweep generator: registers, shared multiplier, cosine table, output stage.
`default_nettype none
module cssw_dp
  import cssw_pkg::*;
#(
  parameter int COS_TABLE_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cssw_cmd_t             cmd,
  output cssw_sts_t                  sts,
  input  wire logic                  in_req_type,
  input  wire logic [1:0]            in_form,
  input  wire logic signed [31:0]    in_start_x,
  input  wire logic signed [31:0]    in_end_x,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  cssw_out_if.source                 out_ch
);

  localparam int QTR = 1 << (COS_TABLE_BITS - 2);

  logic [31:0]        carrier_r, tone_a_r, tone_b_r;
  logic signed [15:0] depth_a_r, depth_b_r, offset_r;
  logic [15:0]        gain_r;
  logic [30:0]        step_r;

  logic signed [31:0] x_r, end_r;
  logic [1:0]         form_r;
  logic               active_r;

  logic signed [65:0] mul_r;
  logic [39:0]        plo_r;
  logic signed [15:0] car_r, ta_r, tb_r;
  logic signed [31:0] sum_r;

  logic               out_valid_r, last_r;
  logic signed [31:0] px_r, py_r;

  logic [14:0] qtab [QTR+1];
  for (genvar k = 0; k <= QTR; k++) begin : g_tab
    assign qtab[k] = qcos_entry(k, COS_TABLE_BITS);
  end

  logic [30:0]        step_eff;
  logic signed [32:0] nx;
  logic               form_is_mod;
  logic               form_is_single;

  assign step_eff = (step_r == 31'd0) ? 31'd1 : step_r;
  assign nx = {x_r[31], x_r} + $signed({2'b00, step_eff});
  assign form_is_mod = (form_r == FORM_MOD);
  assign form_is_single = (form_r == FORM_SINGLE);

  always_comb begin
    if (in_req_type == REQ_START) begin
      sts.go = (in_start_x < in_end_x);
    end else begin
      sts.go = active_r && (nx < $signed({end_r[31], end_r}));
    end
    sts.out_free = !out_valid_r || out_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_r <= '0;
      tone_a_r <= '0;
      tone_b_r <= '0;
      depth_a_r <= '0;
      depth_b_r <= '0;
      offset_r <= '0;
      gain_r <= 16'd256;
      step_r <= 31'd65536;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_CARRIER: carrier_r <= cfg_wdata;
        REG_TONE_A:  tone_a_r <= cfg_wdata;
        REG_TONE_B:  tone_b_r <= cfg_wdata;
        REG_DEPTH_A: depth_a_r <= cfg_wdata[15:0];
        REG_DEPTH_B: depth_b_r <= cfg_wdata[15:0];
        REG_OFFSET:  offset_r <= cfg_wdata[15:0];
        REG_GAIN:    gain_r <= cfg_wdata[15:0];
        REG_STEP:    step_r <= cfg_wdata[30:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      end_r <= '0;
      form_r <= FORM_SINGLE;
      active_r <= 1'b0;
    end else if (cmd.load) begin
      if (in_req_type == REQ_START) begin
        x_r <= in_start_x;
        end_r <= in_end_x;
        form_r <= (in_form == FORM_SPARE) ? FORM_MOD : in_form;
        active_r <= sts.go;
      end else if (active_r) begin
        if (sts.go) begin
          x_r <= nx[31:0];
        end else begin
          active_r <= 1'b0;
        end
      end
    end
  end

  // Multiplier operands; x is taken as a 40-bit two's complement value.
  logic [23:0]        x_hi;
  logic [31:0]        freq_sel;
  logic signed [32:0] mul_a, mul_b;

  assign x_hi = {{8{x_r[31]}}, x_r[31:16]};

  always_comb begin
    case (cmd.op)
      OP_A_LO, OP_A_HI: freq_sel = tone_a_r;
      OP_B_LO, OP_B_HI: freq_sel = tone_b_r;
      default:          freq_sel = carrier_r;
    endcase
  end

  always_comb begin
    mul_a = $signed({1'b0, freq_sel});
    mul_b = $signed({17'b0, x_r[15:0]});
    case (cmd.op)
      OP_C_HI, OP_A_HI, OP_B_HI: begin
        mul_b = $signed({9'b0, x_hi});
      end
      OP_DA: begin
        mul_a = {{17{depth_a_r[15]}}, depth_a_r};
        mul_b = form_is_single ? {{17{car_r[15]}}, car_r} : {{17{ta_r[15]}}, ta_r};
      end
      OP_DB: begin
        mul_a = {{17{depth_b_r[15]}}, depth_b_r};
        mul_b = {{17{tb_r[15]}}, tb_r};
      end
      OP_CG: begin
        mul_a = {{17{car_r[15]}}, car_r};
        mul_b = $signed({17'b0, gain_r});
      end
      OP_FIN: begin
        mul_a = {sum_r[31], sum_r};
        mul_b = form_is_mod ? {mul_r[31], mul_r[31:0]} : $signed({17'b0, gain_r});
      end
      default: begin
      end
    endcase
  end

  // Cosine from the phase fraction in turns.
  logic [39:0]               phase;
  logic [COS_TABLE_BITS-1:0] idx;
  logic [1:0]                quad;
  logic [COS_TABLE_BITS-3:0] rem;
  logic [COS_TABLE_BITS-2:0] fwd_i, rev_i;
  logic signed [15:0]        cos_v;

  assign phase = plo_r + {mul_r[23:0], 16'b0};
  assign idx = phase[39 -: COS_TABLE_BITS];
  assign quad = idx[COS_TABLE_BITS-1 -: 2];
  assign rem = idx[COS_TABLE_BITS-3:0];
  assign fwd_i = {1'b0, rem};
  assign rev_i = (COS_TABLE_BITS - 1)'(QTR) - fwd_i;

  always_comb begin
    case (quad)
      2'd0:    cos_v = $signed({1'b0, qtab[fwd_i]});
      2'd1:    cos_v = -$signed({1'b0, qtab[rev_i]});
      2'd2:    cos_v = -$signed({1'b0, qtab[fwd_i]});
      default: cos_v = $signed({1'b0, qtab[rev_i]});
    endcase
  end

  logic signed [31:0] base;
  assign base = form_is_mod ? 32'sd268435456 : {{2{offset_r[15]}}, offset_r, 14'b0};

  logic mul_en;
  always_comb begin
    case (cmd.op)
      OP_NONE, OP_RES: mul_en = 1'b0;
      default:         mul_en = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) mul_r <= mul_a * mul_b;
    case (cmd.op)
      OP_C_HI, OP_A_HI, OP_B_HI: plo_r <= mul_r[39:0];
      OP_A_LO: car_r <= cos_v;
      OP_B_LO: ta_r <= cos_v;
      OP_DA:   tb_r <= cos_v;
      OP_DB:   sum_r <= base + mul_r[31:0];
      OP_CG: begin
        if (!form_is_single) sum_r <= sum_r + mul_r[31:0];
      end
      default: begin
      end
    endcase
  end

  // Rounding to nearest with ties away from zero, then saturation.
  logic               neg;
  logic [65:0]        mag, rnd;
  logic signed [31:0] y_v;
  logic signed [32:0] last_sum;

  assign neg = mul_r[65];
  assign mag = neg ? 66'(-mul_r) : 66'(mul_r);
  assign rnd = form_is_mod ? ((mag + (66'd1 << 33)) >> 34) : ((mag + (66'd1 << 19)) >> 20);

  always_comb begin
    if (!neg) begin
      y_v = (rnd > 66'd2147483647) ? 32'sh7fffffff : $signed(rnd[31:0]);
    end else begin
      y_v = (rnd > 66'd2147483648) ? 32'sh80000000 : $signed(-rnd[31:0]);
    end
  end

  assign last_sum = {x_r[31], x_r} + $signed({2'b00, step_eff});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_RES && sts.out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RES && sts.out_free) begin
      px_r <= x_r;
      py_r <= y_v;
      last_r <= (last_sum >= $signed({end_r[31], end_r}));
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.point_x = px_r;
  assign out_ch.point_y = py_r;
  assign out_ch.last_point = last_r;

endmodule
`default_nettype wire

// ===== rtl/core/cosine_sum_waveform_sweep.sv =====
// Top level of the cosine-sum waveform sweep generator.
// Requests arrive as beats on in_ch: a start beat loads form, start and end of
// a sweep and yields the point at the start; a next beat steps x by x_step.
// A beat yields no point when the sweep is empty, not running, or the new x
// would reach the end, which also stops the sweep.
// Each point leaves on out_ch as one beat with x, the saturated sample and a
// flag that marks the final point of the sweep.
// Configuration registers are written through cfg_we, cfg_addr and cfg_wdata;
// the user must write them while no request is in flight (not enforced here).
// A request that yields a point steps through the states CLO, CHI, ALO, AHI,
// BLO, BHI, DA, DB, CG, FIN and RES, making ten passes through the one shared
// 33x33 multiplier and the cosine table plus the rounding step; a new request
// is taken only after the result is loaded and the controller returns to idle.
// A request that yields no point is absorbed in its accept cycle.
// Reset clears the sweep state and sets the gain to one and the step to one.
// If out_ch stalls, one finished point waits in the output register; the next
// point then holds in the datapath until that register frees.
`default_nettype none
module cosine_sum_waveform_sweep
  import cssw_pkg::*;
#(
  parameter int COS_TABLE_BITS = 10
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  cssw_in_if.sink                    in_ch,
  cssw_out_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cssw_cmd_t cmd;
  cssw_sts_t sts;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  cssw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cssw_dp #(
    .COS_TABLE_BITS (COS_TABLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_req_type (in_ch.req_type),
    .in_form     (in_ch.form),
    .in_start_x  (in_ch.start_x),
    .in_end_x    (in_ch.end_x),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .out_ch      (out_ch)
  );

endmodule
`default_nettype wire
